[rtl/bssf_pkg.sv]
// Shared types, constants and register codes for the bit-shifted signature finder.
`default_nettype none

package bssf_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_TRACK_DEF   = 16384;
    localparam int NUM_SHIFTS      = 8;
    localparam int NUM_ALIGN       = 2 * NUM_SHIFTS;

    // configuration register indexes
    localparam logic [1:0] REG_PRI_PATTERN = 2'd0;
    localparam logic [1:0] REG_PRI_LENGTH  = 2'd1;
    localparam logic [1:0] REG_SEC_PATTERN = 2'd2;
    localparam logic [1:0] REG_SEC_LENGTH  = 2'd3;

    // reset values of the configuration registers
    localparam logic [63:0] PRI_PATTERN_RST = 64'd8539342599;
    localparam logic [3:0]  PRI_LENGTH_RST  = 4'd5;
    localparam logic [63:0] SEC_PATTERN_RST = 64'd4277929863;
    localparam logic [3:0]  SEC_LENGTH_RST  = 4'd4;

    // result codes
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_PRI  = 2'd1;
    localparam logic [1:0] RES_SEC  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [13:0] match_offset;
        logic [2:0]  bit_shift;
    } out_beat_t;

    // signatures as seen by every cell, lengths already clamped
    typedef struct packed {
        logic [63:0] pri_pattern;
        logic [3:0]  pri_length;
        logic [63:0] sec_pattern;
        logic [3:0]  sec_length;
    } sig_cfg_t;

    // one bit per alignment: index = signature * 8 + shift
    typedef logic [NUM_ALIGN-1:0] align_vec_t;

endpackage

`default_nettype wire

[rtl/bit_shifted_signature_finder.sv]
// Top level of the bit-shifted signature finder: config registers, cell row, track control.
//
// Usage:
//   byte channel (byte_valid / byte_stall / byte_data) carries one raw track byte a beat,
//   with last_byte set on the final byte of the track. One beat is taken every cycle unless byte_stall holds it off.
//   result channel (result_valid / result_stall / result_data) gives one beat a track,
//   in the cycle after the final byte is taken: result code, match offset and bit shift.
//   The search runs on a row of MAX_PATTERN+1 byte cells; cells 1 up to the signature
//   length compare their byte pair at all 8 shifts for that signature and AND their hits
//   into the chain, so every byte is fully checked in the cycle it arrives.
//   The output register decouples the sides: non-final bytes are taken even while a
//   result waits; only a final byte is held off (byte_stall) while result_stall holds
//   an earlier result.
//   Configuration: cfg_write with cfg_index / cfg_data writes one register in a cycle,
//   to be used while no track is in flight.
//   Reset: config registers return to their defaults, the window, byte count and
//   match table clear; no result pending. Bytes past MAX_TRACK are dropped until the
//   final mark.
`default_nettype none

module bit_shifted_signature_finder #(
    parameter int MAX_PATTERN = bssf_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TRACK   = bssf_pkg::MAX_TRACK_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire bssf_pkg::in_beat_t   byte_data,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output bssf_pkg::out_beat_t       result_data,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int NCELL = MAX_PATTERN + 1;

    logic [63:0] pri_pattern_reg, sec_pattern_reg;
    logic [3:0]  pri_length_reg, sec_length_reg;
    bssf_pkg::sig_cfg_t sig_cfg;

    logic take, clear;
    logic [7:0]           cell_byte [NCELL];
    logic [7:0]           cell_next [NCELL];
    bssf_pkg::align_vec_t hit_chain [NCELL+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pri_pattern_reg <= bssf_pkg::PRI_PATTERN_RST;
            pri_length_reg  <= bssf_pkg::PRI_LENGTH_RST;
            sec_pattern_reg <= bssf_pkg::SEC_PATTERN_RST;
            sec_length_reg  <= bssf_pkg::SEC_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bssf_pkg::REG_PRI_PATTERN: pri_pattern_reg <= cfg_data;
                bssf_pkg::REG_PRI_LENGTH:  pri_length_reg  <= cfg_data[3:0];
                bssf_pkg::REG_SEC_PATTERN: sec_pattern_reg <= cfg_data;
                bssf_pkg::REG_SEC_LENGTH:  sec_length_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // lengths above the window clamp to MAX_PATTERN
    always_comb
    begin
        sig_cfg.pri_pattern = pri_pattern_reg;
        sig_cfg.sec_pattern = sec_pattern_reg;
        sig_cfg.pri_length  = (pri_length_reg > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                                : pri_length_reg;
        sig_cfg.sec_length  = (sec_length_reg > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                                : sec_length_reg;
    end

    // cell 0 takes the incoming byte, cell k the byte of cell k-1; compares use the
    // window as it stands after this beat
    assign hit_chain[0] = '1;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign cell_next[k] = byte_data.data_byte;
            end
            else
            begin : g_body
                assign cell_next[k] = cell_byte[k-1];
            end

            bssf_cell #(
                .K(k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (take),
                .clear    (clear),
                .up_byte  (cell_next[k]),
                .low_byte ((k == 0) ? 8'h00 : cell_next[(k == 0) ? 0 : k-1]),
                .sig_cfg  (sig_cfg),
                .hit_in   (hit_chain[k]),
                .hit_out  (hit_chain[k+1]),
                .byte_q   (cell_byte[k])
            );
        end
    endgenerate

    bssf_track #(
        .MAX_TRACK(MAX_TRACK)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_data    (byte_data),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .hit_vec      (hit_chain[NCELL]),
        .pri_length   (sig_cfg.pri_length),
        .sec_length   (sig_cfg.sec_length),
        .take         (take),
        .clear        (clear)
    );

endmodule

`default_nettype wire

[rtl/bssf_cell.sv]
// One window byte cell: holds a track byte and checks its byte pair at all shifts.
`default_nettype none

module bssf_cell #(
    parameter int K = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift_en,
    input  wire logic                    clear,
    input  wire logic [7:0]              up_byte,    // value this cell takes next
    input  wire logic [7:0]              low_byte,   // value the newer neighbor takes next
    input  wire bssf_pkg::sig_cfg_t      sig_cfg,
    input  wire bssf_pkg::align_vec_t    hit_in,
    output bssf_pkg::align_vec_t         hit_out,
    output logic [7:0]                   byte_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    bssf_pkg::align_vec_t own_hit;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = 8'h00;
        end
        else if (shift_en)
        begin
            byte_next = up_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // pair (this, newer) is signature byte L-K; cells above L do not take part
    always_comb
    begin
        logic [15:0] pair;
        logic [15:0] shifted;
        logic [3:0]  len;
        logic [63:0] pat;
        logic [3:0]  diff;
        logic [63:0] pat_sh;
        logic        active;
        pair = {up_byte, low_byte};
        own_hit = '1;
        for (int p = 0; p < 2; p++)
        begin
            len    = (p == 0) ? sig_cfg.pri_length : sig_cfg.sec_length;
            pat    = (p == 0) ? sig_cfg.pri_pattern : sig_cfg.sec_pattern;
            active = (K != 0) && (4'(K) <= len);
            diff   = len - 4'(K);
            pat_sh = pat >> {diff[2:0], 3'b000};
            for (int s = 0; s < bssf_pkg::NUM_SHIFTS; s++)
            begin
                shifted = pair << s;
                if (active && (shifted[15:8] != pat_sh[7:0]))
                begin
                    own_hit[p * bssf_pkg::NUM_SHIFTS + s] = 1'b0;
                end
            end
        end
    end

    assign hit_out = hit_in & own_hit;
    assign byte_q  = byte_reg;

endmodule

`default_nettype wire

[rtl/bssf_track.sv]
// Track control: byte count, first-match table, result choice and output register.
`default_nettype none

module bssf_track #(
    parameter int MAX_TRACK = bssf_pkg::MAX_TRACK_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    byte_valid,
    input  wire bssf_pkg::in_beat_t      byte_data,
    output logic                         byte_stall,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output bssf_pkg::out_beat_t          result_data,
    input  wire bssf_pkg::align_vec_t    hit_vec,
    input  wire logic [3:0]              pri_length,
    input  wire logic [3:0]              sec_length,
    output logic                         take,
    output logic                         clear
);

    localparam int CNT_W = $clog2(MAX_TRACK + 1);
    localparam int OFF_W = $clog2(MAX_TRACK);
    localparam int NA    = bssf_pkg::NUM_ALIGN;

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    bssf_pkg::align_vec_t found_reg, found_next, new_hit;
    logic [OFF_W-1:0] off_reg  [NA];
    logic [OFF_W-1:0] off_next [NA];
    logic [CNT_W-1:0] cand_full [2];
    logic [OFF_W-1:0] cand_off [2];
    logic [1:0]       elig;
    logic             accept;

    logic [1:0]        pick_code;
    logic [OFF_W-1:0]  pick_off;
    logic [2:0]        pick_shift;
    logic [OFF_W+13:0] pick_ext;

    logic                 result_valid_reg, result_valid_next;
    bssf_pkg::out_beat_t  result_data_reg;

    // only a final beat needs the output register free
    assign byte_stall = result_valid_reg && result_stall && byte_data.last_byte;
    assign accept     = byte_valid && !byte_stall;
    assign take       = accept && (cnt_reg < CNT_W'(MAX_TRACK));
    assign clear      = accept && byte_data.last_byte;
    assign cnt_inc    = cnt_reg + CNT_W'(1);

    always_comb
    begin
        elig[0] = take && (pri_length != 4'd0) &&
                  (cnt_inc >= CNT_W'(pri_length) + CNT_W'(1));
        elig[1] = take && (sec_length != 4'd0) &&
                  (cnt_inc >= CNT_W'(sec_length) + CNT_W'(1));
        cand_full[0] = cnt_inc - CNT_W'(pri_length) - CNT_W'(1);
        cand_full[1] = cnt_inc - CNT_W'(sec_length) - CNT_W'(1);
        cand_off[0]  = cand_full[0][OFF_W-1:0];
        cand_off[1]  = cand_full[1][OFF_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            new_hit[i]  = ((i >= bssf_pkg::NUM_SHIFTS) ? elig[1] : elig[0]) &&
                          !found_reg[i] && hit_vec[i];
            off_next[i] = off_reg[i];
            if (new_hit[i])
            begin
                off_next[i] = (i >= bssf_pkg::NUM_SHIFTS) ? cand_off[1] : cand_off[0];
            end
        end
    end

    // lowest index wins: primary before secondary, small shift first
    always_comb
    begin
        pick_code  = bssf_pkg::RES_NONE;
        pick_off   = '0;
        pick_shift = 3'd0;
        for (int i = NA - 1; i >= 0; i--)
        begin
            if (found_reg[i] || new_hit[i])
            begin
                pick_code  = (i >= bssf_pkg::NUM_SHIFTS) ? bssf_pkg::RES_SEC
                                                         : bssf_pkg::RES_PRI;
                pick_off   = off_next[i];
                pick_shift = 3'(i);
            end
        end
    end

    assign pick_ext = {14'd0, pick_off};

    always_comb
    begin
        found_next = found_reg;
        cnt_next   = cnt_reg;
        if (clear)
        begin
            found_next = '0;
            cnt_next   = '0;
        end
        else if (take)
        begin
            found_next = found_reg | new_hit;
            cnt_next   = cnt_inc;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (clear)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            found_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg          <= cnt_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            off_reg[i] <= off_next[i];
        end
        if (clear)
        begin
            result_data_reg.result_code  <= pick_code;
            result_data_reg.match_offset <= pick_ext[13:0];
            result_data_reg.bit_shift    <= pick_shift;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (clear && result_valid_reg) |-> !result_stall)
        else $error("result overwritten while stalled");

    // a final beat leaves a fresh track behind
    a_track_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (found_reg == '0) && (cnt_reg == '0))
        else $error("track state not cleared after final beat");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TRACK))
        else $error("byte count beyond track limit");

    // no match reports zero offset and shift
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_data_reg.result_code == bssf_pkg::RES_NONE) |->
        (result_data_reg.match_offset == 14'd0 && result_data_reg.bit_shift == 3'd0))
        else $error("no-match result carries offset or shift");

endmodule

`default_nettype wire
